@@ rtl/core/dpbf_pkg.sv @@
// ----------------------------------------------------------------------------
// dpbf_pkg
// Shared constants of the displaced-phase blend factor unit.
// ----------------------------------------------------------------------------
package dpbf_pkg;

    // phase slots carried by every input beat
    localparam int N_SLOTS = 3;

    // configuration register indexes
    localparam logic [2:0] REG_FULL_0    = 3'd0;
    localparam logic [2:0] REG_PARTIAL_0 = 3'd1;
    localparam logic [2:0] REG_FULL_1    = 3'd2;
    localparam logic [2:0] REG_PARTIAL_1 = 3'd3;
    localparam logic [2:0] REG_FULL_2    = 3'd4;
    localparam logic [2:0] REG_PARTIAL_2 = 3'd5;
    localparam logic [2:0] REG_MASK      = 3'd6;

    // target phase codes
    localparam logic [1:0] PH_0 = 2'd0;
    localparam logic [1:0] PH_1 = 2'd1;
    localparam logic [1:0] PH_2 = 2'd2;

endpackage

@@ rtl/core/dpbf_front.sv @@
// ----------------------------------------------------------------------------
// dpbf_front
// Ramp terms, denominator sum, num/den products and saturation compare.
// ----------------------------------------------------------------------------
module dpbf_front #(
    parameter int PHASE_COUNT = 3,
    parameter int FRAC_BITS   = 16,
    parameter int W           = FRAC_BITS + 1,
    parameter int DDW         = 2 * W + 3
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [W-1:0]         i_alpha [dpbf_pkg::N_SLOTS],
    input  logic [1:0]           i_target,
    input  logic [W-1:0]         i_full [dpbf_pkg::N_SLOTS],
    input  logic [W-1:0]         i_partial [dpbf_pkg::N_SLOTS],
    input  logic [2:0]           i_mask,
    output logic                 o_valid,
    output logic [DDW:0]         o_rem,
    output logic [DDW-1:0]       o_div,
    output logic                 o_sat
);
    localparam int DW = W + 3;
    localparam int NW = 2 * W;

    // stage 1: captured beat
    logic         r_v1;
    logic [W-1:0] r_x1 [dpbf_pkg::N_SLOTS];
    logic [1:0]   r_t1;

    // stage 2: terms
    logic          r_v2, r_part2, r_zero2;
    logic [DW-1:0] r_den2;
    logic [W-1:0]  r_a2, r_fp2;
    logic [W:0]    r_lin2;

    // stage 3: products
    logic           r_v3, r_zero3;
    logic [NW-1:0]  r_n3;
    logic [DDW-1:0] r_d3;

    logic [DDW:0]   r_rem4;
    logic [DDW-1:0] r_div4;
    logic           r_v4, r_sat4;

    logic [W-1:0]  fe [dpbf_pkg::N_SLOTS];
    logic [W:0]    term [dpbf_pkg::N_SLOTS];
    logic [DW-1:0] n_den;
    logic [W-1:0]  xt, pt, ft;
    logic          disp;

    always_comb begin
        n_den = '0;
        for (int i = 0; i < dpbf_pkg::N_SLOTS; i++) begin
            fe[i] = (i_full[i] > i_partial[i]) ? i_full[i] : i_partial[i];
            if (r_x1[i] <= i_partial[i]) begin
                term[i] = '0;
            end else if (r_x1[i] <= fe[i]) begin
                term[i] = {1'b0, r_x1[i] - i_partial[i]};
            end else begin
                term[i] = {r_x1[i], 1'b0} - {1'b0, i_partial[i]} - {1'b0, fe[i]};
            end
            if (i_mask[i] && (i < PHASE_COUNT)) begin
                n_den = n_den + DW'(term[i]);
            end
        end
        xt   = '0;
        pt   = '0;
        ft   = '0;
        disp = 1'b0;
        case (r_t1)
            dpbf_pkg::PH_0: begin
                xt = r_x1[0]; pt = i_partial[0]; ft = fe[0]; disp = i_mask[0];
            end
            dpbf_pkg::PH_1: begin
                xt = r_x1[1]; pt = i_partial[1]; ft = fe[1]; disp = i_mask[1];
            end
            dpbf_pkg::PH_2: begin
                xt = r_x1[2]; pt = i_partial[2]; ft = fe[2];
                disp = i_mask[2] && (PHASE_COUNT > 2);
            end
            default: begin
                disp = 1'b0;
            end
        endcase
    end

    logic [NW-1:0]  n_num;
    logic [DDW-1:0] n_dd;
    logic           n_sat;

    always_comb begin
        n_num = r_part2 ? NW'(r_a2 * r_a2) : NW'(r_lin2);
        n_dd  = r_part2 ? DDW'(r_fp2 * r_den2) : DDW'(r_den2);
        n_sat = ({{(DDW-NW){1'b0}}, r_n3} >= r_d3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x1    <= i_alpha;
            r_t1    <= i_target;
            r_den2  <= n_den;
            r_a2    <= xt - pt;
            r_fp2   <= ft - pt;
            r_lin2  <= {xt, 1'b0} - {1'b0, pt} - {1'b0, ft};
            r_part2 <= (xt <= ft);
            r_zero2 <= !disp || (xt <= pt);
            r_zero3 <= r_zero2;
            r_n3    <= n_num;
            r_d3    <= n_dd;
            // zero or saturated beats run through the divider as 0/1
            if (r_zero3 || n_sat) begin
                r_rem4 <= '0;
                r_div4 <= DDW'(1);
            end else begin
                r_rem4 <= (DDW+1)'(r_n3);
                r_div4 <= r_d3;
            end
            r_sat4 <= n_sat && !r_zero3;
        end
    end

    // the product stage reads stage-2 terms; part flag moves with them
    assign o_valid = r_v4;
    assign o_rem   = r_rem4;
    assign o_div   = r_div4;
    assign o_sat   = r_sat4;
endmodule

@@ rtl/core/dpbf_div_cell.sv @@
// ----------------------------------------------------------------------------
// dpbf_div_cell
// One restoring division step, registered toward the next cell.
// ----------------------------------------------------------------------------
module dpbf_div_cell #(
    parameter int FRAC_BITS = 16,
    parameter int DDW       = 37
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic                 i_valid,
    input  logic [DDW:0]         i_rem,
    input  logic [DDW-1:0]       i_div,
    input  logic [FRAC_BITS-1:0] i_quo,
    input  logic                 i_sat,
    output logic                 o_valid,
    output logic [DDW:0]         o_rem,
    output logic [DDW-1:0]       o_div,
    output logic [FRAC_BITS-1:0] o_quo,
    output logic                 o_sat
);
    logic [DDW:0] shifted;
    logic         ge;

    logic                 r_valid, r_sat;
    logic [DDW:0]         r_rem;
    logic [DDW-1:0]       r_div;
    logic [FRAC_BITS-1:0] r_quo;

    // remainder stays below divisor, so the doubled value fits
    assign shifted = {i_rem[DDW-1:0], 1'b0};
    assign ge      = (shifted >= {1'b0, i_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= ge ? shifted - {1'b0, i_div} : shifted;
            r_div <= i_div;
            r_quo <= {i_quo[FRAC_BITS-2:0], ge};
            r_sat <= i_sat;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_quo   = r_quo;
    assign o_sat   = r_sat;
endmodule

@@ rtl/core/displaced_phase_blend_factor_unit.sv @@
// ----------------------------------------------------------------------------
// displaced_phase_blend_factor_unit
// Blend factor of a target displacing phase per mesh cell, Q format.
// ----------------------------------------------------------------------------
// Takes one cell beat per cycle while the output is not stalled and returns
// one factor beat per cell, in order. The pipeline is made of the four
// front stages (capture, ramp terms, products, compare), the chain of
// FRAC_BITS divider cells, one quotient bit per cell, and the output
// register. A stall on the output freezes the whole pipeline; tready
// then drops on the input.
module displaced_phase_blend_factor_unit #(
    parameter int PHASE_COUNT = 3,
    parameter int FRAC_BITS   = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_s_tvalid,
    output logic o_s_tready,
    // alpha_0, alpha_1, alpha_2, target_phase
    input  logic [((3*(FRAC_BITS+1)+2+7)/8)*8-1:0] i_s_tdata,
    output logic o_m_tvalid,
    input  logic i_m_tready,
    // blend_factor
    output logic [((FRAC_BITS+1+7)/8)*8-1:0] o_m_tdata,
    input  logic i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [FRAC_BITS:0] i_cfg_wdata
);
    localparam int W     = FRAC_BITS + 1;
    localparam int DDW   = 2 * W + 3;
    localparam int OUT_W = ((W+7)/8)*8;
    localparam logic [W-1:0] ONE = W'(1) << FRAC_BITS;

    logic [W-1:0] r_full [dpbf_pkg::N_SLOTS];
    logic [W-1:0] r_partial [dpbf_pkg::N_SLOTS];
    logic [2:0]   r_mask;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < dpbf_pkg::N_SLOTS; i++) begin
                r_full[i]    <= ONE;
                r_partial[i] <= '0;
            end
            r_mask <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dpbf_pkg::REG_FULL_0:    r_full[0]    <= i_cfg_wdata;
                dpbf_pkg::REG_PARTIAL_0: r_partial[0] <= i_cfg_wdata;
                dpbf_pkg::REG_FULL_1:    r_full[1]    <= i_cfg_wdata;
                dpbf_pkg::REG_PARTIAL_1: r_partial[1] <= i_cfg_wdata;
                dpbf_pkg::REG_FULL_2:    r_full[2]    <= i_cfg_wdata;
                dpbf_pkg::REG_PARTIAL_2: r_partial[2] <= i_cfg_wdata;
                dpbf_pkg::REG_MASK:      r_mask       <= i_cfg_wdata[2:0];
                default: begin
                end
            endcase
        end
    end

    logic         en;
    logic         r_out_valid;
    logic [W-1:0] r_out;
    logic [W-1:0] alpha [dpbf_pkg::N_SLOTS];

    assign en = !r_out_valid || i_m_tready;

    always_comb begin
        for (int i = 0; i < dpbf_pkg::N_SLOTS; i++) begin
            alpha[i] = i_s_tdata[i*W +: W];
        end
    end

    logic                 cv [FRAC_BITS+1];
    logic [DDW:0]         crem [FRAC_BITS+1];
    logic [DDW-1:0]       cdiv [FRAC_BITS+1];
    logic [FRAC_BITS-1:0] cquo [FRAC_BITS+1];
    logic                 csat [FRAC_BITS+1];

    dpbf_front #(
        .PHASE_COUNT(PHASE_COUNT),
        .FRAC_BITS  (FRAC_BITS),
        .W          (W),
        .DDW        (DDW)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_s_tvalid),
        .i_alpha  (alpha),
        .i_target (i_s_tdata[3*W +: 2]),
        .i_full   (r_full),
        .i_partial(r_partial),
        .i_mask   (r_mask),
        .o_valid  (cv[0]),
        .o_rem    (crem[0]),
        .o_div    (cdiv[0]),
        .o_sat    (csat[0])
    );
    assign cquo[0] = '0;

    for (genvar g = 0; g < FRAC_BITS; g++) begin : g_cell
        dpbf_div_cell #(
            .FRAC_BITS(FRAC_BITS),
            .DDW      (DDW)
        ) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_en   (en),
            .i_valid(cv[g]),
            .i_rem  (crem[g]),
            .i_div  (cdiv[g]),
            .i_quo  (cquo[g]),
            .i_sat  (csat[g]),
            .o_valid(cv[g+1]),
            .o_rem  (crem[g+1]),
            .o_div  (cdiv[g+1]),
            .o_quo  (cquo[g+1]),
            .o_sat  (csat[g+1])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= cv[FRAC_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= csat[FRAC_BITS] ? ONE : {1'b0, cquo[FRAC_BITS]};
        end
    end

    assign o_s_tready = en;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_W'(r_out);

`ifndef ASSERT_OFF
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out <= ONE))
        else $error("blend factor above one");
    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output stalled");
    a_sat_quo: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cv[FRAC_BITS] && csat[FRAC_BITS]) |-> (cquo[FRAC_BITS] == '0))
        else $error("saturated beat carries quotient bits");
`endif
endmodule

@@ tb/tb_displaced_phase_blend_factor_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_displaced_phase_blend_factor_unit
// Self-checking bench for the blend factor unit: a table of directed cells
// and then random cells over several threshold/mask settings. Each factor
// beat is compared with an in-bench computation of the factor.
// ----------------------------------------------------------------------------
module tb_displaced_phase_blend_factor_unit;

    localparam int FB  = 16;
    localparam int VW  = FB + 1;
    localparam int SDW = ((3*VW+2+7)/8)*8;
    localparam int MDW = ((VW+7)/8)*8;
    localparam logic [VW-1:0] ONE = 17'd65536;
    localparam int LAT = FB + 5;

    typedef struct packed {
        logic [1:0]    target;
        logic [VW-1:0] a2;
        logic [VW-1:0] a1;
        logic [VW-1:0] a0;
    } t_cell;

    typedef struct {
        t_cell         c;
        logic          has_exp;
        logic [VW-1:0] exp_val;
    } t_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_s_tvalid = 1'b0;
    logic o_s_tready;
    logic [SDW-1:0] i_s_tdata = '0;
    logic o_m_tvalid;
    logic i_m_tready = 1'b0;
    logic [MDW-1:0] o_m_tdata;
    logic i_cfg_we = 1'b0;
    logic [2:0] i_cfg_idx = dpbf_pkg::REG_FULL_0;
    logic [FB:0] i_cfg_wdata = '0;

    displaced_phase_blend_factor_unit u_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    logic [VW-1:0] full_thr [3];
    logic [VW-1:0] part_thr [3];
    logic [2:0]    disp_mask;
    logic [VW-1:0] factor_q [$];
    int  n_err = 0;
    bit  busy_free = 0;   // no idling stretch
    logic [VW-1:0] rx_check_q [$];

    task automatic report(input string msg);
        $display("MISMATCH %0t: %s", $realtime, msg);
        n_err++;
    endtask

    function automatic logic [63:0] eff_full(int i);
        return 64'((full_thr[i] > part_thr[i]) ? full_thr[i] : part_thr[i]);
    endfunction

    function automatic logic [63:0] slope2(int i, logic [63:0] x);
        logic [63:0] p, f;
        p = 64'(part_thr[i]);
        f = eff_full(i);
        if (x <= p) return '0;
        if (x <= f) return x - p;
        return 2*x - p - f;
    endfunction

    function automatic logic [VW-1:0] blend_factor(t_cell c);
        logic [63:0] al [3];
        logic [63:0] den, x, p, f, n, d, q, r;
        int t;
        al[0] = 64'(c.a0); al[1] = 64'(c.a1); al[2] = 64'(c.a2);
        t = int'(c.target);
        den = '0;
        if (t >= dpbf_pkg::N_SLOTS || !disp_mask[t]) return '0;
        for (int i = 0; i < dpbf_pkg::N_SLOTS; i++)
            if (disp_mask[i]) den += slope2(i, al[i]);
        x = al[t];
        p = 64'(part_thr[t]);
        f = eff_full(t);
        if (x <= p) return '0;
        if (x <= f) begin
            n = (x - p) * (x - p);
            d = (f - p) * den;
        end else begin
            n = 2*x - p - f;
            d = den;
        end
        if (d == 0) return '0;
        if (n >= d) return ONE;
        q = '0;
        r = n;
        for (int k = 0; k < FB; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= d) begin
                r -= d;
                q |= 64'd1;
            end
        end
        return (q > 64'(ONE)) ? ONE : q[VW-1:0];
    endfunction

    // output side: random stall, check at rising edge
    always @(negedge i_clk) begin
        if (!i_rst_n) i_m_tready <= 1'b0;
        else i_m_tready <= busy_free ? 1'b1 : ($urandom_range(99) >= 32);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (factor_q.size() == 0) begin
                report($sformatf("unexpected factor %0d", o_m_tdata[VW-1:0]));
            end else begin
                logic [VW-1:0] e;
                logic [VW-1:0] hx;
                e = factor_q.pop_front();
                hx = rx_check_q.pop_front();
                if (o_m_tdata[VW-1:0] !== e)
                    report($sformatf("blend_factor got %0d exp %0d",
                                     o_m_tdata[VW-1:0], e));
                else if (hx !== e)
                    report($sformatf("table value %0d, computed %0d", hx, e));
            end
        end
    end

    task automatic cfg_write(logic [2:0] idx, logic [FB:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_wdata <= val;
        case (idx)
            dpbf_pkg::REG_FULL_0:    full_thr[0] = val;
            dpbf_pkg::REG_PARTIAL_0: part_thr[0] = val;
            dpbf_pkg::REG_FULL_1:    full_thr[1] = val;
            dpbf_pkg::REG_PARTIAL_1: part_thr[1] = val;
            dpbf_pkg::REG_FULL_2:    full_thr[2] = val;
            dpbf_pkg::REG_PARTIAL_2: part_thr[2] = val;
            dpbf_pkg::REG_MASK:      disp_mask = val[2:0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        while (factor_q.size() != 0) @(negedge i_clk);
        repeat (LAT + 4) @(negedge i_clk);
    endtask

    // called at a falling edge; leaves at a falling edge after acceptance
    task automatic send_cell(t_cell c, logic has_exp, logic [VW-1:0] ev);
        logic [VW-1:0] e;
        while (!busy_free && $urandom_range(99) < 32) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        e = blend_factor(c);
        i_s_tvalid <= 1'b1;
        i_s_tdata <= SDW'(c);
        do @(posedge i_clk); while (!o_s_tready);
        factor_q.push_back(e);
        rx_check_q.push_back(has_exp ? ev : e);
        @(negedge i_clk);
    endtask

    function automatic logic [VW-1:0] rand_frac();
        case ($urandom_range(5))
            0: return '0;
            1: return ONE;
            2: return VW'($urandom_range(131071));
            default: return VW'($urandom_range(65536));
        endcase
    endfunction

    function automatic t_cell rand_cell();
        t_cell c;
        c.a0 = rand_frac();
        c.a1 = rand_frac();
        c.a2 = rand_frac();
        c.target = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
        return c;
    endfunction

    task automatic rand_config();
        logic [2:0] full_idx [3];
        logic [2:0] part_idx [3];
        full_idx = '{dpbf_pkg::REG_FULL_0, dpbf_pkg::REG_FULL_1, dpbf_pkg::REG_FULL_2};
        part_idx = '{dpbf_pkg::REG_PARTIAL_0, dpbf_pkg::REG_PARTIAL_1,
                     dpbf_pkg::REG_PARTIAL_2};
        for (int i = 0; i < 3; i++) begin
            logic [FB:0] a, b;
            a = rand_frac();
            b = rand_frac();
            if ($urandom_range(3) != 0 && a > b) begin
                logic [FB:0] t; t = a; a = b; b = t;
            end
            cfg_write(full_idx[i], b);
            cfg_write(part_idx[i], a);
        end
        cfg_write(dpbf_pkg::REG_MASK, (FB+1)'($urandom_range(7)));
    endtask

    t_row dir_tab [] = '{
        '{'{dpbf_pkg::PH_0, 17'd0, 17'd0, 17'd0}, 1'b1, 17'd0},          // mask clear
        '{'{2'd3, ONE, ONE, ONE}, 1'b1, 17'd0},                 // bad target
        '{'{dpbf_pkg::PH_0, 17'd0, 17'd0, 17'd0}, 1'b1, 17'd0},           // empty sum
        '{'{dpbf_pkg::PH_0, 17'd0, 17'd0, ONE}, 1'b1, ONE},              // lone phase full
        '{'{dpbf_pkg::PH_0, 17'd0, 17'd0, 17'd32768}, 1'b1, 17'd32768},  // lone phase half
        '{'{dpbf_pkg::PH_0, 17'd0, 17'd0, 17'h1ffff}, 1'b1, ONE},        // above one
        '{'{dpbf_pkg::PH_1, 17'd0, 17'd40000, 17'd20000}, 1'b0, 17'd0},
        '{'{dpbf_pkg::PH_2, ONE, 17'd1, 17'd1}, 1'b0, 17'd0},
        '{'{dpbf_pkg::PH_1, 17'h1ffff, 17'h1ffff, 17'h1ffff}, 1'b0, 17'd0},
        '{'{dpbf_pkg::PH_0, 17'd12345, 17'd54321, 17'd1}, 1'b0, 17'd0}
    };

    initial begin
        full_thr = '{ONE, ONE, ONE};
        part_thr = '{'0, '0, '0};
        disp_mask = 3'd0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        send_cell(dir_tab[0].c, dir_tab[0].has_exp, dir_tab[0].exp_val);
        wait_drain();
        cfg_write(dpbf_pkg::REG_MASK, 17'b001);
        for (int i = 1; i < 6; i++)
            send_cell(dir_tab[i].c, dir_tab[i].has_exp, dir_tab[i].exp_val);
        wait_drain();
        cfg_write(dpbf_pkg::REG_MASK, 17'b111);
        cfg_write(dpbf_pkg::REG_FULL_1, 17'd1000);
        cfg_write(dpbf_pkg::REG_PARTIAL_1, 17'd2000);   // unordered thresholds
        cfg_write(dpbf_pkg::REG_PARTIAL_2, ONE);
        cfg_write(dpbf_pkg::REG_FULL_2, 17'd0);
        cfg_write(dpbf_pkg::REG_FULL_0, 17'h1ffff);
        cfg_write(dpbf_pkg::REG_PARTIAL_0, 17'd0);
        for (int i = 6; i < dir_tab.size(); i++)
            send_cell(dir_tab[i].c, dir_tab[i].has_exp, dir_tab[i].exp_val);
        for (int i = 0; i < 40; i++)
            send_cell(rand_cell(), 1'b0, '0);
        wait_drain();
        for (int ph = 0; ph < 7; ph++) begin
            rand_config();
            busy_free = (ph == 3);
            for (int i = 0; i < 100; i++)
                send_cell(rand_cell(), 1'b0, '0);
            i_s_tvalid <= 1'b0;
            busy_free = 0;
            wait_drain();
        end
        if (n_err == 0)
            $display("tb_displaced_phase_blend_factor_unit: clean");
        else
            $display("tb_displaced_phase_blend_factor_unit: errors");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_displaced_phase_blend_factor_unit: errors");
        $finish;
    end
endmodule
